[hdl/rnudc_pkg.sv]
// ----------------------------------------------------------------------------
// rnudc_pkg
// Types and constants shared by the programmable radix up/down digit counter,
// its channel interfaces and its checker.
// ----------------------------------------------------------------------------
package rnudc_pkg;

    localparam int DEF_MAX_DIGITS = 8;

    localparam int CMD_W      = 3;
    localparam int VALUE_W    = 32;
    localparam int NIB_W      = 4;
    localparam int RADIX_W    = 5;
    localparam int DIGITS_W   = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam int DIV_BITS   = 4;
    localparam int DIV_CYC    = VALUE_W / DIV_BITS;
    localparam int DIV_CNT_W  = $clog2(DIV_CYC);

    localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
    localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(16);

    localparam logic [CFG_IDX_W-1:0] CFG_RADIX  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_DIGITS = CFG_IDX_W'(1);

    localparam logic [RADIX_W-1:0]  RADIX_RST  = RADIX_W'(2);
    localparam logic [DIGITS_W-1:0] DIGITS_RST = DIGITS_W'(4);

    typedef enum logic [CMD_W-1:0] {
        CMD_INC  = 3'd0,
        CMD_DEC  = 3'd1,
        CMD_CLR  = 3'd2,
        CMD_MAX  = 3'd3,
        CMD_LOAD = 3'd4
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WALK,
        ST_DIV,
        ST_LDCHK,
        ST_CONV
    } state_t;

endpackage

[hdl/rnudc_if.sv]
// ----------------------------------------------------------------------------
// rnudc channel interfaces
// Valid/ready channels for command beats, result beats and register writes.
// ----------------------------------------------------------------------------
interface rnudc_cmd_if;
    logic                                valid;
    logic                                ready;
    logic [rnudc_pkg::CMD_W-1:0]         cmd;
    logic [rnudc_pkg::VALUE_W-1:0]       load_value;

    modport source (output valid, output cmd, output load_value, input ready);
    modport sink   (input valid, input cmd, input load_value, output ready);
endinterface

interface rnudc_res_if;
    logic                                valid;
    logic                                ready;
    logic [rnudc_pkg::VALUE_W-1:0]       count_value;
    logic [rnudc_pkg::VALUE_W-1:0]       digits_packed;
    logic                                overflow;

    modport source (output valid, output count_value, output digits_packed,
                    output overflow, input ready);
    modport sink   (input valid, input count_value, input digits_packed,
                    input overflow, output ready);
endinterface

interface rnudc_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [rnudc_pkg::CFG_IDX_W-1:0]     index;
    logic [rnudc_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[hdl/radix_n_updown_digit_counter.sv]
// ----------------------------------------------------------------------------
// radix_n_updown_digit_counter
// Multi-digit counter in a configurable base with increment, decrement,
// clear, set to maximum and load commands, one result beat per command.
// ----------------------------------------------------------------------------
// One command is worked at a time, one digit after another. After the accepting
// cycle, increment and decrement walk the carry or borrow through up to n
// digits (n is the number of digits in use), load runs a radix-16 restoring
// divider over the 32-bit value for each digit followed by a range check, and
// clear, set maximum and unused codes need no walk. Every command ends with
// Horner accumulation over the n digits through one 32 by 5 bit multiplier
// that forms the binary value. The result sits in an output register, so a
// result waiting to be taken does not keep the next command beat from being
// accepted.
module radix_n_updown_digit_counter #(
    parameter int MAX_DIGITS = rnudc_pkg::DEF_MAX_DIGITS
) (
    input  logic               clk,
    input  logic               rst_n,
    rnudc_cmd_if.sink          item_in,
    rnudc_res_if.source        item_out,
    rnudc_cfg_if.sink          cfg
);

    localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam int CNT_W = $clog2(MAX_DIGITS + 1);
    localparam int VW    = rnudc_pkg::VALUE_W;
    localparam int NW    = rnudc_pkg::NIB_W;
    localparam int RW    = rnudc_pkg::RADIX_W;

    rnudc_pkg::state_t state_reg, state_next;

    logic [RW-1:0]                      radix_reg;
    logic [rnudc_pkg::DIGITS_W-1:0]     digits_reg;
    logic [NW-1:0]                      store_reg [MAX_DIGITS];
    logic [NW-1:0]                      store_next [MAX_DIGITS];
    logic [NW-1:0]                      ld_reg [MAX_DIGITS];
    logic [NW-1:0]                      ld_next [MAX_DIGITS];
    logic [IDX_W-1:0]                   idx_reg, idx_next;
    logic                               dec_reg, dec_next;
    logic                               refused_reg, refused_next;
    logic [VW-1:0]                      divd_reg, divd_next;
    logic [RW-1:0]                      rem_reg, rem_next;
    logic [rnudc_pkg::DIV_CNT_W-1:0]    bcnt_reg, bcnt_next;
    logic [VW-1:0]                      acc_reg, acc_next;
    logic                               ovalid_reg, ovalid_next;
    logic [VW-1:0]                      ocount_reg, ocount_next;
    logic [VW-1:0]                      opacked_reg, opacked_next;
    logic                               oflow_reg, oflow_next;

    logic [RW-1:0]      base;
    logic [CNT_W-1:0]   n_eff;
    logic [IDX_W-1:0]   last_idx;
    logic [NW-1:0]      wrap_val;
    logic [NW-1:0]      cur_digit;
    logic               wraps;
    logic               is_last;
    logic               in_acc;
    logic               out_free;
    logic               conv_hold;
    logic               div_digit_done;
    logic [VW+RW-1:0]   prod;
    logic [VW-1:0]      digits_flat;
    logic [VW-1:0]      q_step;
    logic [RW-1:0]      r_step;

    always_comb
    begin
        if (radix_reg < rnudc_pkg::RADIX_MIN)
            base = rnudc_pkg::RADIX_MIN;
        else if (radix_reg > rnudc_pkg::RADIX_MAX)
            base = rnudc_pkg::RADIX_MAX;
        else
            base = radix_reg;

        if (digits_reg == '0)
            n_eff = CNT_W'(1);
        else if (digits_reg > rnudc_pkg::DIGITS_W'(MAX_DIGITS))
            n_eff = CNT_W'(MAX_DIGITS);
        else
            n_eff = CNT_W'(digits_reg);
    end

    assign last_idx  = IDX_W'(n_eff - CNT_W'(1));
    assign is_last   = (idx_reg == last_idx);
    assign wrap_val  = NW'(base - RW'(1));
    assign cur_digit = store_reg[idx_reg];
    assign wraps     = dec_reg ? (cur_digit == '0)
                               : ((RW'(cur_digit) + RW'(1)) >= base);

    assign in_acc    = item_in.valid && item_in.ready;
    assign out_free  = !ovalid_reg || item_out.ready;
    assign conv_hold = (idx_reg == '0) && !out_free;
    assign div_digit_done = (bcnt_reg == rnudc_pkg::DIV_CNT_W'(rnudc_pkg::DIV_CYC - 1));

    assign prod = acc_reg * base;

    always_comb
    begin
        logic [RW-1:0] r;
        logic [VW-1:0] q;
        r = rem_reg;
        q = divd_reg;
        for (int s = 0; s < rnudc_pkg::DIV_BITS; s++)
        begin
            r = {r[RW-2:0], q[VW-1]};
            q = {q[VW-2:0], 1'b0};
            if (r >= base)
            begin
                r    = r - base;
                q[0] = 1'b1;
            end
        end
        q_step = q;
        r_step = r;
    end

    always_comb
    begin
        digits_flat = '0;
        for (int j = 0; j < MAX_DIGITS; j++)
        begin
            if (CNT_W'(j) < n_eff)
                digits_flat[j*NW +: NW] = store_reg[j];
        end
    end

    assign item_in.ready  = (state_reg == rnudc_pkg::ST_IDLE);
    assign cfg.ready      = 1'b1;

    assign item_out.valid         = ovalid_reg;
    assign item_out.count_value   = ocount_reg;
    assign item_out.digits_packed = opacked_reg;
    assign item_out.overflow      = oflow_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rnudc_pkg::ST_IDLE:
            begin
                if (in_acc)
                begin
                    case (item_in.cmd) inside
                        rnudc_pkg::CMD_INC, rnudc_pkg::CMD_DEC:
                            state_next = rnudc_pkg::ST_WALK;
                        rnudc_pkg::CMD_LOAD:
                            state_next = rnudc_pkg::ST_DIV;
                        default:
                            state_next = rnudc_pkg::ST_CONV;
                    endcase
                end
            end
            rnudc_pkg::ST_WALK:
            begin
                if (!wraps || is_last)
                    state_next = rnudc_pkg::ST_CONV;
            end
            rnudc_pkg::ST_DIV:
            begin
                if (div_digit_done && is_last)
                    state_next = rnudc_pkg::ST_LDCHK;
            end
            rnudc_pkg::ST_LDCHK:
                state_next = rnudc_pkg::ST_CONV;
            rnudc_pkg::ST_CONV:
            begin
                if ((idx_reg == '0) && out_free)
                    state_next = rnudc_pkg::ST_IDLE;
            end
            default:
                state_next = rnudc_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        store_next   = store_reg;
        ld_next      = ld_reg;
        idx_next     = idx_reg;
        dec_next     = dec_reg;
        refused_next = refused_reg;
        divd_next    = divd_reg;
        rem_next     = rem_reg;
        bcnt_next    = bcnt_reg;
        acc_next     = acc_reg;
        ocount_next  = ocount_reg;
        opacked_next = opacked_reg;
        oflow_next   = oflow_reg;
        ovalid_next  = ovalid_reg && !item_out.ready;

        unique case (state_reg)
            rnudc_pkg::ST_IDLE:
            begin
                if (in_acc)
                begin
                    refused_next = 1'b0;
                    dec_next     = (item_in.cmd == rnudc_pkg::CMD_DEC);
                    idx_next     = last_idx;
                    acc_next     = '0;
                    divd_next    = item_in.load_value;
                    rem_next     = '0;
                    bcnt_next    = '0;
                    case (item_in.cmd) inside
                        rnudc_pkg::CMD_INC, rnudc_pkg::CMD_DEC, rnudc_pkg::CMD_LOAD:
                            idx_next = '0;
                        rnudc_pkg::CMD_CLR:
                        begin
                            for (int j = 0; j < MAX_DIGITS; j++)
                            begin
                                if (CNT_W'(j) < n_eff)
                                    store_next[j] = '0;
                            end
                        end
                        rnudc_pkg::CMD_MAX:
                        begin
                            for (int j = 0; j < MAX_DIGITS; j++)
                            begin
                                if (CNT_W'(j) < n_eff)
                                    store_next[j] = wrap_val;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            rnudc_pkg::ST_WALK:
            begin
                if (!wraps)
                begin
                    for (int j = 0; j < MAX_DIGITS; j++)
                    begin
                        if (IDX_W'(j) < idx_reg)
                            store_next[j] = dec_reg ? wrap_val : '0;
                    end
                    store_next[idx_reg] = dec_reg ? (cur_digit - NW'(1))
                                                  : (cur_digit + NW'(1));
                    idx_next = last_idx;
                    acc_next = '0;
                end
                else if (is_last)
                begin
                    refused_next = 1'b1;
                    idx_next     = last_idx;
                    acc_next     = '0;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            rnudc_pkg::ST_DIV:
            begin
                divd_next = q_step;
                if (div_digit_done)
                begin
                    ld_next[idx_reg] = r_step[NW-1:0];
                    rem_next         = '0;
                    bcnt_next        = '0;
                    if (!is_last)
                        idx_next = idx_reg + IDX_W'(1);
                end
                else
                begin
                    rem_next  = r_step;
                    bcnt_next = bcnt_reg + rnudc_pkg::DIV_CNT_W'(1);
                end
            end
            rnudc_pkg::ST_LDCHK:
            begin
                if (divd_reg == '0)
                begin
                    for (int j = 0; j < MAX_DIGITS; j++)
                    begin
                        if (CNT_W'(j) < n_eff)
                            store_next[j] = ld_reg[j];
                    end
                end
                else
                begin
                    refused_next = 1'b1;
                end
                idx_next = last_idx;
                acc_next = '0;
            end
            rnudc_pkg::ST_CONV:
            begin
                if (!conv_hold)
                begin
                    acc_next = prod[VW-1:0] + VW'(cur_digit);
                    if (idx_reg == '0)
                    begin
                        ovalid_next  = 1'b1;
                        ocount_next  = prod[VW-1:0] + VW'(cur_digit);
                        opacked_next = digits_flat;
                        oflow_next   = refused_reg;
                    end
                    else
                    begin
                        idx_next = idx_reg - IDX_W'(1);
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= rnudc_pkg::ST_IDLE;
            radix_reg  <= rnudc_pkg::RADIX_RST;
            digits_reg <= rnudc_pkg::DIGITS_RST;
            ovalid_reg <= 1'b0;
            for (int j = 0; j < MAX_DIGITS; j++)
                store_reg[j] <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
            store_reg  <= store_next;
            if (cfg.valid && cfg.ready)
            begin
                unique case (cfg.index)
                    rnudc_pkg::CFG_RADIX:
                        radix_reg <= cfg.data[RW-1:0];
                    rnudc_pkg::CFG_DIGITS:
                        digits_reg <= cfg.data[rnudc_pkg::DIGITS_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ld_reg      <= ld_next;
        idx_reg     <= idx_next;
        dec_reg     <= dec_next;
        refused_reg <= refused_next;
        divd_reg    <= divd_next;
        rem_reg     <= rem_next;
        bcnt_reg    <= bcnt_next;
        acc_reg     <= acc_next;
        ocount_reg  <= ocount_next;
        opacked_reg <= opacked_next;
        oflow_reg   <= oflow_next;
    end

endmodule

[hdl/rnudc_checker.sv]
// ----------------------------------------------------------------------------
// rnudc_checker
// Port-level checks on the digit counter, bound to its top level.
// ----------------------------------------------------------------------------
module rnudc_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_ready,
    input logic                              out_valid,
    input logic                              out_ready,
    input logic [rnudc_pkg::VALUE_W-1:0]     out_count,
    input logic [rnudc_pkg::VALUE_W-1:0]     out_packed,
    input logic                              out_flow
);

    logic [1:0] pend_reg, pend_next;
    logic       in_acc;
    logic       out_acc;

    assign in_acc  = in_valid && in_ready;
    assign out_acc = out_valid && out_ready;

    always_comb
    begin
        pend_next = pend_reg;
        if (in_acc && !out_acc)
            pend_next = pend_reg + 2'd1;
        else if (!in_acc && out_acc)
            pend_next = pend_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pend_reg <= 2'd0;
        else
            pend_reg <= pend_next;
    end

    // A stalled result beat keeps its valid and its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_count)
                                    && $stable(out_packed) && $stable(out_flow))
        else $error("result beat changed while stalled");

    // Commands are worked one at a time.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> !in_ready)
        else $error("command accepted while another is in progress");

    // Every result beat answers a command that has not yet been answered.
    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pend_reg != 2'd0)
        else $error("result beat without an outstanding command");

    // At most one command in work and one result waiting.
    a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg != 2'd3)
        else $error("too many outstanding commands");

endmodule

bind radix_n_updown_digit_counter rnudc_checker u_rnudc_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (item_in.valid),
    .in_ready   (item_in.ready),
    .out_valid  (item_out.valid),
    .out_ready  (item_out.ready),
    .out_count  (item_out.count_value),
    .out_packed (item_out.digits_packed),
    .out_flow   (item_out.overflow)
);
